// File: hdl/ptsb_pkg.sv
`default_nettype none

package ptsb_pkg;

   localparam int PERIOD_W     = 32;
   localparam int SLOT_FIELD_W = 4;
   localparam int STATUS_W     = 3;
   localparam int KIND_W       = 2;

   localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STOP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

   localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BADPER  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_STOPPED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FIRED   = 3'd4;

   // write enables of the two slot memories
   typedef struct packed {
      logic timer;
      logic link;
   } mem_wen_type;

endpackage

`default_nettype wire

// File: hdl/ptsb_free_find.sv
`default_nettype none

module ptsb_free_find #(
   parameter int NUM_SLOTS = 16,
   parameter int IDX_W     = 4
) (
   input  wire  logic [NUM_SLOTS-1:0] slot_busy,
   output logic                       free_found,
   output logic [IDX_W-1:0]           free_idx
);

   // lowest clear bit wins
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!slot_busy[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

// File: hdl/ptsb_slot_store.sv
`default_nettype none

module ptsb_slot_store #(
   parameter int NUM_SLOTS   = 16,
   parameter int IDX_W       = 4,
   parameter int COUNT_WIDTH = 32
) (
   input  wire  logic                       clock,
   input  wire  logic                       rd_en,
   input  wire  logic [IDX_W-1:0]           rd_addr,
   input  wire  ptsb_pkg::mem_wen_type      wen,
   input  wire  logic [IDX_W-1:0]           tim_addr,
   input  wire  logic [2*COUNT_WIDTH:0]     tim_wdata,
   input  wire  logic [IDX_W-1:0]           link_addr,
   input  wire  logic [IDX_W-1:0]           link_wdata,
   output logic [2*COUNT_WIDTH:0]           tim_rdata_ff,
   output logic [IDX_W-1:0]                 link_rdata_ff
);

   // timer word: remaining count over reload period
   logic [2*COUNT_WIDTH:0] timer_mem [NUM_SLOTS];
   logic [IDX_W-1:0]       link_mem  [NUM_SLOTS];

   always_ff @(posedge clock) begin
      if (wen.timer) begin
         timer_mem[tim_addr] <= tim_wdata;
      end
      if (rd_en) begin
         tim_rdata_ff <= timer_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wen.link) begin
         link_mem[link_addr] <= link_wdata;
      end
      if (rd_en) begin
         link_rdata_ff <= link_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: hdl/periodic_timer_slot_bank_unit.sv
// Channel   Ports                                     Transfer
// request   start, busy, req_kind/period/slot         start && !busy
// response  rsp_strobe, rsp_status/slot_index/last    rsp_strobe, one cycle, no stall
//
// Add and stop are handled when accepted; the response follows on the next cycle.
// A tick walks the N slots in the ring: the walk reads one slot a cycle
// from the slot memories, whose registered read is overlapped with the
// previous slot's write-back.
// Synchronous reset empties the ring and frees all slots; no clearing pass.
// busy stays high for the whole tick walk; responses are never held.
`default_nettype none

module periodic_timer_slot_bank_unit #(
   parameter int NUM_SLOTS   = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  wire  logic                            clock,
   input  wire  logic                            reset,
   input  wire  logic                            start,
   output logic                                  busy,
   input  wire  logic [ptsb_pkg::KIND_W-1:0]     req_kind,
   input  wire  logic [ptsb_pkg::PERIOD_W-1:0]   req_period,
   input  wire  logic [ptsb_pkg::SLOT_FIELD_W-1:0] req_slot,
   output logic                                  rsp_strobe,
   output logic [ptsb_pkg::STATUS_W-1:0]         rsp_status,
   output logic [ptsb_pkg::SLOT_FIELD_W-1:0]     rsp_slot_index,
   output logic                                  rsp_last
);

   localparam int IDX_W = $clog2(NUM_SLOTS);
   localparam int CW    = COUNT_WIDTH;
   localparam int TW    = 2 * COUNT_WIDTH + 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_DRAIN
   } state_type;

   state_type                         state_ff;
   logic                              busy_ff;
   logic [NUM_SLOTS-1:0]              slot_busy_ff;
   logic [NUM_SLOTS-1:0]              running_ff;
   logic [IDX_W-1:0]                  head_ff;
   logic [IDX_W-1:0]                  tail_ff;
   logic                              empty_ff;
   logic [IDX_W-1:0]                  node_ff;
   logic [IDX_W-1:0]                  prev_ff;
   logic                              have_prev_ff;
   logic [IDX_W-1:0]                  visit_ff;
   logic                              pend_valid_ff;
   logic [IDX_W-1:0]                  pend_idx_ff;
   logic                              rsp_strobe_ff;
   logic [ptsb_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic [ptsb_pkg::SLOT_FIELD_W-1:0] rsp_slot_ff;
   logic                              rsp_last_ff;

   logic                  accept;
   logic [CW-1:0]         per;
   logic                  per_zero;
   logic                  free_found;
   logic [IDX_W-1:0]      free_idx;
   logic [IDX_W-1:0]      req_idx;
   logic                  stop_in_range;

   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   ptsb_pkg::mem_wen_type wen;
   logic [IDX_W-1:0]      tim_addr;
   logic [TW-1:0]         tim_wdata;
   logic [IDX_W-1:0]      link_addr;
   logic [IDX_W-1:0]      link_wdata;
   logic [TW-1:0]         tim_rdata;
   logic [IDX_W-1:0]      link_rdata;

   logic [CW:0]           rem_rd;
   logic [CW-1:0]         reload_rd;
   logic [CW:0]           rem_dec;
   logic                  fire;
   logic                  node_running;
   logic                  at_tail;
   logic                  walk_end;
   logic                  becomes_empty;

   assign busy           = busy_ff;
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_last       = rsp_last_ff;

   assign accept        = start && !busy_ff;
   assign per           = CW'(req_period);
   assign per_zero      = (per == '0);
   assign req_idx       = IDX_W'(req_slot);
   assign stop_in_range = (32'(req_slot) < 32'(NUM_SLOTS));

   assign rem_rd        = tim_rdata[TW-1:CW];
   assign reload_rd     = tim_rdata[CW-1:0];
   assign rem_dec       = (rem_rd != '0) ? (rem_rd - (CW+1)'(1)) : rem_rd;
   assign fire          = (rem_dec == '0);
   assign node_running  = running_ff[node_ff];
   assign at_tail       = (node_ff == tail_ff);
   assign walk_end      = at_tail || (visit_ff == IDX_W'(NUM_SLOTS - 1));
   assign becomes_empty = !node_running && !have_prev_ff && at_tail;

   ptsb_free_find #(
      .NUM_SLOTS(NUM_SLOTS),
      .IDX_W    (IDX_W)
   ) u_free_find (
      .slot_busy (slot_busy_ff),
      .free_found(free_found),
      .free_idx  (free_idx)
   );

   ptsb_slot_store #(
      .NUM_SLOTS  (NUM_SLOTS),
      .IDX_W      (IDX_W),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_slot_store (
      .clock        (clock),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .wen          (wen),
      .tim_addr     (tim_addr),
      .tim_wdata    (tim_wdata),
      .link_addr    (link_addr),
      .link_wdata   (link_wdata),
      .tim_rdata_ff (tim_rdata),
      .link_rdata_ff(link_rdata)
   );

   // memory port control
   always_comb begin
      rd_en      = 1'b0;
      rd_addr    = head_ff;
      wen        = '0;
      tim_addr   = node_ff;
      tim_wdata  = tim_rdata;
      link_addr  = prev_ff;
      link_wdata = link_rdata;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_kind == ptsb_pkg::KIND_ADD && !per_zero && free_found) begin
               wen.timer = 1'b1;
               tim_addr  = free_idx;
               tim_wdata = {({1'b0, per} + (CW+1)'(1)), per};
               if (!empty_ff) begin
                  wen.link   = 1'b1;
                  link_addr  = tail_ff;
                  link_wdata = free_idx;
               end
            end
            if (accept && req_kind == ptsb_pkg::KIND_TICK && !empty_ff) begin
               rd_en   = 1'b1;
               rd_addr = head_ff;
            end
         end
         S_WALK: begin
            if (node_running) begin
               wen.timer = 1'b1;
               tim_addr  = node_ff;
               tim_wdata = fire ? {{1'b0, reload_rd}, reload_rd} : {rem_dec, reload_rd};
            end else if (have_prev_ff) begin
               // unlink: predecessor skips the stopped slot
               wen.link   = 1'b1;
               link_addr  = prev_ff;
               link_wdata = link_rdata;
            end
            if (!walk_end) begin
               rd_en   = 1'b1;
               rd_addr = link_rdata;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         busy_ff       <= 1'b0;
         slot_busy_ff  <= '0;
         running_ff    <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         empty_ff      <= 1'b1;
         have_prev_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               rsp_strobe_ff <= accept && (req_kind == ptsb_pkg::KIND_ADD
                                           || req_kind == ptsb_pkg::KIND_STOP);
               if (accept) begin
                  case (req_kind)
                     ptsb_pkg::KIND_ADD: begin
                        rsp_last_ff   <= 1'b1;
                        if (per_zero) begin
                           rsp_status_ff <= ptsb_pkg::ST_BADPER;
                           rsp_slot_ff   <= '0;
                        end else if (!free_found) begin
                           rsp_status_ff <= ptsb_pkg::ST_FULL;
                           rsp_slot_ff   <= '0;
                        end else begin
                           rsp_status_ff          <= ptsb_pkg::ST_ADDED;
                           rsp_slot_ff            <= ptsb_pkg::SLOT_FIELD_W'(free_idx);
                           slot_busy_ff[free_idx] <= 1'b1;
                           running_ff[free_idx]   <= 1'b1;
                           if (empty_ff) begin
                              head_ff  <= free_idx;
                              empty_ff <= 1'b0;
                           end
                           tail_ff <= free_idx;
                        end
                     end
                     ptsb_pkg::KIND_STOP: begin
                        rsp_last_ff   <= 1'b1;
                        rsp_status_ff <= ptsb_pkg::ST_STOPPED;
                        rsp_slot_ff   <= req_slot;
                        if (stop_in_range && slot_busy_ff[req_idx]) begin
                           running_ff[req_idx] <= 1'b0;
                        end
                     end
                     ptsb_pkg::KIND_TICK: begin
                        if (!empty_ff) begin
                           state_ff      <= S_WALK;
                           busy_ff       <= 1'b1;
                           node_ff       <= head_ff;
                           have_prev_ff  <= 1'b0;
                           visit_ff      <= '0;
                           pend_valid_ff <= 1'b0;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_WALK: begin
               rsp_strobe_ff <= node_running && fire && pend_valid_ff;
               if (node_running) begin
                  // a firing is held back until the next firing or the drain so last can be marked
                  if (fire) begin
                     if (pend_valid_ff) begin
                        rsp_status_ff <= ptsb_pkg::ST_FIRED;
                        rsp_slot_ff   <= ptsb_pkg::SLOT_FIELD_W'(pend_idx_ff);
                        rsp_last_ff   <= 1'b0;
                     end
                     pend_valid_ff <= 1'b1;
                     pend_idx_ff   <= node_ff;
                  end
                  prev_ff      <= node_ff;
                  have_prev_ff <= 1'b1;
               end else begin
                  slot_busy_ff[node_ff] <= 1'b0;
                  if (!have_prev_ff) begin
                     if (at_tail) begin
                        empty_ff <= 1'b1;
                     end else begin
                        head_ff <= link_rdata;
                     end
                  end else if (at_tail) begin
                     tail_ff <= prev_ff;
                  end
               end
               if (walk_end) begin
                  state_ff <= S_DRAIN;
                  if (becomes_empty) begin
                     head_ff <= '0;
                     tail_ff <= '0;
                  end
               end else begin
                  node_ff  <= link_rdata;
                  visit_ff <= visit_ff + IDX_W'(1);
               end
            end
            S_DRAIN: begin
               rsp_strobe_ff <= pend_valid_ff;
               if (pend_valid_ff) begin
                  rsp_status_ff <= ptsb_pkg::ST_FIRED;
                  rsp_slot_ff   <= ptsb_pkg::SLOT_FIELD_W'(pend_idx_ff);
                  rsp_last_ff   <= 1'b1;
               end
               pend_valid_ff <= 1'b0;
               state_ff      <= S_IDLE;
               busy_ff       <= 1'b0;
            end
            default: begin
               rsp_strobe_ff <= 1'b0;
               state_ff      <= S_IDLE;
               busy_ff       <= 1'b0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: hdl/ptsb_checker.sv
`default_nettype none

module ptsb_checker (
   input  wire  logic                              clock,
   input  wire  logic                              reset,
   input  wire  logic                              start,
   input  wire  logic                              busy,
   input  wire  logic [ptsb_pkg::KIND_W-1:0]       req_kind,
   input  wire  logic                              rsp_strobe,
   input  wire  logic [ptsb_pkg::STATUS_W-1:0]     rsp_status,
   input  wire  logic [ptsb_pkg::SLOT_FIELD_W-1:0] rsp_slot_index,
   input  wire  logic                              rsp_last
);

   // add and stop answer with a single transaction
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ptsb_pkg::ST_FIRED |-> rsp_last)
      else $error("non-fire response without last");

   a_reject_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == ptsb_pkg::ST_FULL || rsp_status == ptsb_pkg::ST_BADPER)
      |-> rsp_slot_index == '0)
      else $error("rejected add reports a slot");

   a_add_resp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_kind == ptsb_pkg::KIND_ADD
      |=> rsp_strobe && (rsp_status == ptsb_pkg::ST_ADDED
         || rsp_status == ptsb_pkg::ST_FULL || rsp_status == ptsb_pkg::ST_BADPER))
      else $error("add without its response");

   a_stop_resp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_kind == ptsb_pkg::KIND_STOP
      |=> rsp_strobe && rsp_status == ptsb_pkg::ST_STOPPED)
      else $error("stop without its response");

endmodule

bind periodic_timer_slot_bank_unit ptsb_checker u_ptsb_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_kind      (req_kind),
   .rsp_strobe    (rsp_strobe),
   .rsp_status    (rsp_status),
   .rsp_slot_index(rsp_slot_index),
   .rsp_last      (rsp_last)
);

`default_nettype wire
